// ===== sv/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants for the averaged proximity steering block:
// window depths, derived sum widths, direction codes and control structs.
// ----------------------------------------------------------------------------
package aps_pkg;

	// window depths and field widths
	localparam int FRONT_DEPTH = 64;
	localparam int LEFT_DEPTH  = 16;
	localparam int RIGHT_DEPTH = 16;
	localparam int SAMPLE_W    = 10;
	localparam int DIR_W       = 2;
	localparam int CFG_INDEX_W = 2;

	// running sums hold depth times the largest sample
	localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
	localparam int FRONT_SUM_W = $clog2(FRONT_DEPTH * SAMPLE_MAX + 1);
	localparam int LEFT_SUM_W  = $clog2(LEFT_DEPTH * SAMPLE_MAX + 1);
	localparam int RIGHT_SUM_W = $clog2(RIGHT_DEPTH * SAMPLE_MAX + 1);

	typedef logic [SAMPLE_W-1:0] sample_t;

	// movement direction codes
	typedef enum logic [DIR_W-1:0] {
		DIR_FORWARD  = 2'd0,
		DIR_BACKWARD = 2'd1,
		DIR_RIGHT    = 2'd2,
		DIR_LEFT     = 2'd3
	} dir_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRONT_UPPER = 2'd0,
		CFG_FRONT_LOWER = 2'd1,
		CFG_LEFT_WALL   = 2'd2,
		CFG_RIGHT_WALL  = 2'd3
	} cfg_reg_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_DECIDE
	} state_t;

	// per-cell control: shift in from neighbor, or load the fill value
	typedef struct packed {
		logic shift;
		logic fill;
	} cell_ctl_t;

	// flags of the word under decision
	typedef struct packed {
		logic run;
		logic autonomous;
		logic cmd_valid;
		dir_t cmd_dir;
	} item_flags_t;

	typedef struct packed {
		sample_t front_upper;
		sample_t front_lower;
		sample_t left_wall;
		sample_t right_wall;
	} thresholds_t;

	// front window refill request
	typedef struct packed {
		logic    en;
		sample_t value;
	} refill_t;

endpackage

// ===== sv/aps_cell.sv =====
// ----------------------------------------------------------------------------
// aps_cell
// One window entry. Takes its neighbor's sample on a shift, or the fill
// value on a refill; the last cell of a row holds the oldest sample.
// ----------------------------------------------------------------------------
module aps_cell import aps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  sample_t   din,
	input  sample_t   fill_value,
	output sample_t   dout
);

	sample_t entry_q;

	// entry register, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.fill) begin
			entry_q <= fill_value;
		end else if (ctl.shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

// ===== sv/aps_steer.sv =====
// ----------------------------------------------------------------------------
// aps_steer
// Direction decision: applies the manual command, the autonomous priority
// rules and turn tracking, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module aps_steer import aps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  item_flags_t       flags,
	input  thresholds_t       thr,
	input  sample_t           front_avg,
	input  sample_t           left_avg,
	input  sample_t           right_avg,
	input  logic              out_ready,
	output refill_t           refill,
	output logic              out_valid,
	output logic [DIR_W-1:0]  direction,
	output logic              turn_start,
	output sample_t           front_average,
	output sample_t           left_average,
	output sample_t           right_average
);

	dir_t    current_q;
	dir_t    tracked_q;
	dir_t    start_dir;
	dir_t    next_dir;
	logic    turn;
	logic    out_valid_q;
	dir_t    direction_q;
	logic    turn_start_q;
	sample_t front_average_q;
	sample_t left_average_q;
	sample_t right_average_q;

	// command first, then the autonomous rules in priority order
	always_comb begin
		start_dir = flags.cmd_valid ? flags.cmd_dir : current_q;
		next_dir  = start_dir;
		refill    = '0;
		if (flags.run && flags.autonomous) begin
			priority if (start_dir == DIR_FORWARD && front_avg > thr.front_upper) begin
				next_dir     = DIR_RIGHT;
				refill.en    = 1'b1;
				refill.value = thr.front_upper;
			end else if ((start_dir == DIR_LEFT || start_dir == DIR_RIGHT)
					&& front_avg < thr.front_lower) begin
				next_dir     = DIR_FORWARD;
				refill.en    = 1'b1;
				refill.value = thr.front_lower;
			end else if (start_dir == DIR_LEFT && left_avg > thr.left_wall) begin
				next_dir = DIR_RIGHT;
			end else if (start_dir == DIR_RIGHT && right_avg > thr.right_wall) begin
				next_dir = DIR_LEFT;
			end
		end
		turn = flags.run && (next_dir != tracked_q);
	end

	// direction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= DIR_FORWARD;
			tracked_q <= DIR_FORWARD;
		end else if (fire) begin
			current_q <= next_dir;
			if (turn) begin
				tracked_q <= next_dir;
			end
		end
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (fire) begin
			direction_q     <= next_dir;
			turn_start_q    <= turn;
			front_average_q <= front_avg;
			left_average_q  <= left_avg;
			right_average_q <= right_avg;
		end
	end

	assign out_valid     = out_valid_q;
	assign direction     = direction_q;
	assign turn_start    = turn_start_q;
	assign front_average = front_average_q;
	assign left_average  = left_average_q;
	assign right_average = right_average_q;

endmodule

// ===== sv/averaged_proximity_steering.sv =====
// ----------------------------------------------------------------------------
// averaged_proximity_steering
// Averages front, left and right proximity samples over shift windows and
// steers a walking robot by threshold rules on the averages.
// ----------------------------------------------------------------------------
// Usage: an input word (three samples, run/autonomy flags, optional manual
// direction) is taken on in_valid & in_ready. One result word (direction,
// turn_start, three averages) comes back per input word on out_valid /
// out_ready. The four thresholds are written on cfg_valid & cfg_ready with
// cfg_index selecting the register; cfg_ready is always high.
// Timing: the accept cycle shifts each sample into its row of cells and
// updates the running sums; the decide step then divides the sums, decides
// the direction and, on a forward/turn change, reloads all front cells with
// the threshold at once. The result word is registered as that step ends;
// no new word is taken until this two-step sequencer is back in idle.
// Stall: the result waits in the output register while a new word is taken;
// the decide step holds until that register is free.
// Reset: all window cells and sums clear, direction returns to forward and
// the thresholds return to 150, 40, 40, 40.
// ----------------------------------------------------------------------------
module averaged_proximity_steering import aps_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_W-1:0]    front_sample,
	input  logic [SAMPLE_W-1:0]    left_sample,
	input  logic [SAMPLE_W-1:0]    right_sample,
	input  logic                   run_enable,
	input  logic                   autonomous_enable,
	input  logic                   command_valid,
	input  logic [DIR_W-1:0]       command_direction,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DIR_W-1:0]       direction,
	output logic                   turn_start,
	output logic [SAMPLE_W-1:0]    front_average,
	output logic [SAMPLE_W-1:0]    left_average,
	output logic [SAMPLE_W-1:0]    right_average,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]    cfg_data
);

	state_t                 state_q;
	state_t                 state_d;
	logic                   accept;
	logic                   fire;
	thresholds_t            thr_q;
	item_flags_t            flags_q;
	refill_t                refill;
	logic                   refill_fire;
	cell_ctl_t              front_ctl;
	cell_ctl_t              side_ctl;
	sample_t                front_din  [FRONT_DEPTH];
	sample_t                front_cell [FRONT_DEPTH];
	sample_t                left_din   [LEFT_DEPTH];
	sample_t                left_cell  [LEFT_DEPTH];
	sample_t                right_din  [RIGHT_DEPTH];
	sample_t                right_cell [RIGHT_DEPTH];
	logic [FRONT_SUM_W-1:0] front_sum_q;
	logic [LEFT_SUM_W-1:0]  left_sum_q;
	logic [RIGHT_SUM_W-1:0] right_sum_q;
	sample_t                front_avg;
	sample_t                left_avg;
	sample_t                right_avg;

	// threshold registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.front_upper <= sample_t'(150);
			thr_q.front_lower <= sample_t'(40);
			thr_q.left_wall   <= sample_t'(40);
			thr_q.right_wall  <= sample_t'(40);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FRONT_UPPER: thr_q.front_upper <= cfg_data;
				CFG_FRONT_LOWER: thr_q.front_lower <= cfg_data;
				CFG_LEFT_WALL:   thr_q.left_wall   <= cfg_data;
				CFG_RIGHT_WALL:  thr_q.right_wall  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECIDE;
			ST_DECIDE: if (!out_valid || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		fire     = (state_q == ST_DECIDE) && (!out_valid || out_ready);
	end

	assign accept      = in_valid && in_ready;
	assign refill_fire = fire && refill.en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// flags of the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_q.run        <= run_enable;
			flags_q.autonomous <= autonomous_enable;
			flags_q.cmd_valid  <= command_valid;
			flags_q.cmd_dir    <= dir_t'(command_direction);
		end
	end

	// cell rows: each sample enters cell 0, oldest leaves the last cell
	assign front_ctl = '{shift: accept, fill: refill_fire};
	assign side_ctl  = '{shift: accept, fill: 1'b0};

	for (genvar gi = 0; gi < FRONT_DEPTH; gi++) begin : g_front
		if (gi == 0) begin : g_head
			assign front_din[gi] = front_sample;
		end else begin : g_link
			assign front_din[gi] = front_cell[gi-1];
		end
		aps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (front_ctl),
			.din        (front_din[gi]),
			.fill_value (refill.value),
			.dout       (front_cell[gi])
		);
	end

	for (genvar gi = 0; gi < LEFT_DEPTH; gi++) begin : g_left
		if (gi == 0) begin : g_head
			assign left_din[gi] = left_sample;
		end else begin : g_link
			assign left_din[gi] = left_cell[gi-1];
		end
		aps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (side_ctl),
			.din        (left_din[gi]),
			.fill_value ('0),
			.dout       (left_cell[gi])
		);
	end

	for (genvar gi = 0; gi < RIGHT_DEPTH; gi++) begin : g_right
		if (gi == 0) begin : g_head
			assign right_din[gi] = right_sample;
		end else begin : g_link
			assign right_din[gi] = right_cell[gi-1];
		end
		aps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (side_ctl),
			.din        (right_din[gi]),
			.fill_value ('0),
			.dout       (right_cell[gi])
		);
	end

	// running sums: add the new sample, drop the oldest; a refill sets the front sum to the fill value times depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_sum_q <= '0;
			left_sum_q  <= '0;
			right_sum_q <= '0;
		end else if (accept) begin
			front_sum_q <= front_sum_q - FRONT_SUM_W'(front_cell[FRONT_DEPTH-1])
				+ FRONT_SUM_W'(front_sample);
			left_sum_q  <= left_sum_q - LEFT_SUM_W'(left_cell[LEFT_DEPTH-1])
				+ LEFT_SUM_W'(left_sample);
			right_sum_q <= right_sum_q - RIGHT_SUM_W'(right_cell[RIGHT_DEPTH-1])
				+ RIGHT_SUM_W'(right_sample);
		end else if (refill_fire) begin
			front_sum_q <= FRONT_SUM_W'(FRONT_SUM_W'(refill.value)
				* FRONT_SUM_W'(FRONT_DEPTH));
		end
	end

	// window averages, floor of sum over depth
	assign front_avg = sample_t'(front_sum_q / FRONT_DEPTH);
	assign left_avg  = sample_t'(left_sum_q / LEFT_DEPTH);
	assign right_avg = sample_t'(right_sum_q / RIGHT_DEPTH);

	// decision and output word
	aps_steer u_steer (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.flags         (flags_q),
		.thr           (thr_q),
		.front_avg     (front_avg),
		.left_avg      (left_avg),
		.right_avg     (right_avg),
		.out_ready     (out_ready),
		.refill        (refill),
		.out_valid     (out_valid),
		.direction     (direction),
		.turn_start    (turn_start),
		.front_average (front_average),
		.left_average  (left_average),
		.right_average (right_average)
	);

endmodule
